/* src/tccw_pkg.sv */
// Package for the text console cell writer.
// Holds the command codes, character codes and register indexes.
// No dependencies.
package tccw_pkg;

    // Classified command carried from the front end to the back end
    typedef enum logic [1:0] {
        OP_PUT,
        OP_BACKSPACE,
        OP_NEWLINE,
        OP_GOTO
    } t_op;

    // Character codes with special meaning
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_LINEFEED  = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Input item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_GOTO = 1'b1;

    // Configuration register indexes
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    // Fixed field widths
    localparam int ADDR_W   = 11;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int ATTR_W   = 8;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 5;

endpackage

/* src/tccw_front.sv */
// Front end of the text console cell writer: classifies each input beat and
// precomputes the clamped cursor target of goto items.
// Depends on tccw_pkg.
module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               i_kind,
    input  logic [tccw_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tccw_pkg::COLUMN_W-1:0]      i_target_column,
    input  logic [tccw_pkg::ROW_W-1:0]         i_target_row,
    output tccw_pkg::t_op                      o_op,
    output logic [tccw_pkg::CHAR_W-1:0]        o_char,
    output logic [$clog2(COLUMNS*ROWS)-1:0]    o_pos,
    output logic [$clog2(COLUMNS)-1:0]         o_col
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_CELL = CELLS - 1;
    localparam int POS_W     = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int COL_MAX   = (1 << tccw_pkg::COLUMN_W) - 1;
    localparam int ROW_MAX   = (1 << tccw_pkg::ROW_W) - 1;
    localparam int GOTO_MAX  = ROW_MAX * COLUMNS + COL_MAX;
    localparam int SUM_W0    = $clog2(GOTO_MAX + 1);
    localparam int SUM_W     = (SUM_W0 > POS_W) ? SUM_W0 : POS_W;
    localparam int COL_ENTRIES = 1 << tccw_pkg::COLUMN_W;

    logic [COL_W-1:0] col_mod [COL_ENTRIES];
    logic [SUM_W-1:0] goto_sum;
    logic             goto_clamp;

    // Constant table: target column modulo the row length
    for (genvar g = 0; g < COL_ENTRIES; g++) begin : g_col_mod
        assign col_mod[g] = COL_W'(g % COLUMNS);
    end

    // Goto target: row * COLUMNS + column, saturated at the last cell
    assign goto_sum   = SUM_W'(i_target_row) * SUM_W'(COLUMNS) + SUM_W'(i_target_column);
    assign goto_clamp = goto_sum > SUM_W'(LAST_CELL);

    // Classification
    always_comb begin
        o_char = i_char_code;
        o_pos  = goto_clamp ? POS_W'(LAST_CELL) : goto_sum[POS_W-1:0];
        o_col  = goto_clamp ? COL_W'(COLUMNS - 1) : col_mod[i_target_column];
        if (i_kind == tccw_pkg::KIND_GOTO) begin
            o_op = tccw_pkg::OP_GOTO;
        end else begin
            case (i_char_code)
                tccw_pkg::CH_BACKSPACE: o_op = tccw_pkg::OP_BACKSPACE;
                tccw_pkg::CH_LINEFEED:  o_op = tccw_pkg::OP_NEWLINE;
                tccw_pkg::CH_RETURN:    o_op = tccw_pkg::OP_NEWLINE;
                default:                o_op = tccw_pkg::OP_PUT;
            endcase
        end
    end

endmodule

/* src/tccw_fifo.sv */
// Small command queue between the front and back ends of the cell writer.
// Generic width and depth; ready depends only on the fill level.
// No dependencies.
module tccw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_not_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_not_full  = r_count != CNT_W'(DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_data      = r_mem[r_rd_ptr];

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* src/tccw_back.sv */
// Back end of the cell writer: owns the cursor, executes queued commands and
// holds the output register for cell write beats.
// Depends on tccw_pkg.
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_head_valid,
    input  tccw_pkg::t_op                      i_op,
    input  logic [tccw_pkg::CHAR_W-1:0]        i_char,
    input  logic [$clog2(COLUMNS*ROWS)-1:0]    i_pos,
    input  logic [$clog2(COLUMNS)-1:0]         i_col,
    input  logic [tccw_pkg::ATTR_W-1:0]        i_attr,
    output logic                               o_pop,
    output logic [$clog2(COLUMNS*ROWS)-1:0]    o_cursor,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tccw_pkg::ADDR_W-1:0]        o_cell_address,
    output logic [tccw_pkg::ATTR_W+tccw_pkg::CHAR_W-1:0] o_cell_value
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_CELL = CELLS - 1;
    localparam int POS_W     = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int NL_W      = POS_W + 1;
    localparam int EXT_W     = POS_W + tccw_pkg::ADDR_W;
    localparam int VALUE_W   = tccw_pkg::ATTR_W + tccw_pkg::CHAR_W;

    logic [POS_W-1:0]   r_cursor, n_cursor;
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_out_valid, n_out_valid;
    logic [tccw_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [VALUE_W-1:0] r_value, n_value;

    logic               writes;
    logic               out_free;
    logic [NL_W-1:0]    nl_sum;
    logic [POS_W-1:0]   wr_pos;
    logic [EXT_W-1:0]   wr_pos_ext;
    logic [tccw_pkg::CHAR_W-1:0] wr_char;

    assign writes   = (i_op == tccw_pkg::OP_PUT) || (i_op == tccw_pkg::OP_BACKSPACE);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_head_valid && (!writes || out_free);
    assign nl_sum   = NL_W'(r_cursor) + NL_W'(COLUMNS) - NL_W'(r_col);

    // Cursor update and write data
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        wr_pos   = r_cursor;
        wr_char  = i_char;
        case (i_op)
            tccw_pkg::OP_PUT: begin
                if (r_cursor != POS_W'(LAST_CELL)) begin
                    n_cursor = r_cursor + POS_W'(1);
                    n_col    = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + COL_W'(1);
                end
            end
            tccw_pkg::OP_BACKSPACE: begin
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - POS_W'(1);
                    n_col    = (r_col == '0) ? COL_W'(COLUMNS - 1) : r_col - COL_W'(1);
                end
                wr_pos  = n_cursor;
                wr_char = tccw_pkg::CH_SPACE;
            end
            tccw_pkg::OP_NEWLINE: begin
                // last row saturates at the last cell
                if (nl_sum > NL_W'(LAST_CELL)) begin
                    n_cursor = POS_W'(LAST_CELL);
                    n_col    = COL_W'(COLUMNS - 1);
                end else begin
                    n_cursor = nl_sum[POS_W-1:0];
                    n_col    = '0;
                end
            end
            tccw_pkg::OP_GOTO: begin
                n_cursor = i_pos;
                n_col    = i_col;
            end
            default: begin
                n_cursor = r_cursor;
            end
        endcase
    end

    // Output register: low address bits of the written cell
    assign wr_pos_ext = EXT_W'(wr_pos);

    always_comb begin
        n_out_valid = r_out_valid;
        n_addr      = r_addr;
        n_value     = r_value;
        if (o_pop && writes) begin
            n_out_valid = 1'b1;
            n_addr      = wr_pos_ext[tccw_pkg::ADDR_W-1:0];
            n_value     = {i_attr, wr_char};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cursor <= n_cursor;
                r_col    <= n_col;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_value <= n_value;
    end

    assign o_cursor       = r_cursor;
    assign o_out_valid    = r_out_valid;
    assign o_cell_address = r_addr;
    assign o_cell_value   = r_value;

endmodule

/* src/text_console_cell_writer.sv */
// Text console cell writer: top level with color registers and assertions.
// Depends on tccw_pkg, tccw_front, tccw_fifo and tccw_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one beat per item: a
//   character (i_kind = 0) or a cursor goto (i_kind = 1) with column and row.
//   Output channel (o_out_valid / i_out_ready) delivers one beat for each
//   cell write: any character code but LF and CR. Newline and goto beats
//   move the cursor only and produce no output beat. Color registers are
//   written via i_cfg_we / i_cfg_index / i_cfg_data (index 0 foreground, 1
//   background); the user must do so only while idle (not enforced).
// Timing:
//   An input beat is registered in its queue entry, then in the output
//   register. Sustained throughput is one item per cycle, each pop moving the
//   cursor, as long as the output register is free for cell writes.
//   o_in_ready depends only on the fill level of the 2-entry command queue.
// Reset and stalls:
//   Synchronous reset puts the cursor at the top left cell, clears both
//   colors and empties the queue. When the receiver stalls, the output
//   register holds its beat, the queue fills, then o_in_ready drops.
module text_console_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [tccw_pkg::CHAR_W-1:0]         i_char_code,
    input  logic [tccw_pkg::COLUMN_W-1:0]       i_target_column,
    input  logic [tccw_pkg::ROW_W-1:0]          i_target_row,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tccw_pkg::ADDR_W-1:0]         o_cell_address,
    output logic [tccw_pkg::ATTR_W+tccw_pkg::CHAR_W-1:0] o_cell_value
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_CELL = CELLS - 1;
    localparam int POS_W     = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int OP_W      = $bits(tccw_pkg::t_op);
    localparam int ENTRY_W   = OP_W + tccw_pkg::CHAR_W + POS_W + COL_W;
    localparam int QUEUE_DEPTH = 2;

    logic [tccw_pkg::COLOR_W-1:0] r_foreground;
    logic [tccw_pkg::COLOR_W-1:0] r_background;

    tccw_pkg::t_op               w_front_op;
    logic [tccw_pkg::CHAR_W-1:0] w_front_char;
    logic [POS_W-1:0]            w_front_pos;
    logic [COL_W-1:0]            w_front_col;
    logic                        w_push;
    logic [ENTRY_W-1:0]          w_entry_in;
    logic [ENTRY_W-1:0]          w_head;
    logic                        w_head_valid;
    logic                        w_pop;
    tccw_pkg::t_op               w_head_op;
    logic [tccw_pkg::CHAR_W-1:0] w_head_char;
    logic [POS_W-1:0]            w_head_pos;
    logic [COL_W-1:0]            w_head_col;
    logic [POS_W-1:0]            w_cursor;

    // Color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foreground <= '0;
            r_background <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tccw_pkg::REG_FOREGROUND: r_foreground <= i_cfg_data;
                tccw_pkg::REG_BACKGROUND: r_background <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: classify the beat
    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_target_column (i_target_column),
        .i_target_row    (i_target_row),
        .o_op            (w_front_op),
        .o_char          (w_front_char),
        .o_pos           (w_front_pos),
        .o_col           (w_front_col)
    );

    // Command queue
    assign w_push     = i_in_valid && o_in_ready;
    assign w_entry_in = {w_front_op, w_front_char, w_front_pos, w_front_col};

    tccw_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_entry_in),
        .o_not_full  (o_in_ready),
        .i_pop       (w_pop),
        .o_not_empty (w_head_valid),
        .o_data      (w_head)
    );

    assign w_head_op   = tccw_pkg::t_op'(w_head[ENTRY_W-1 -: OP_W]);
    assign w_head_char = w_head[POS_W+COL_W +: tccw_pkg::CHAR_W];
    assign w_head_pos  = w_head[COL_W +: POS_W];
    assign w_head_col  = w_head[COL_W-1:0];

    // Back end: cursor and cell writes
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_op           (w_head_op),
        .i_char         (w_head_char),
        .i_pos          (w_head_pos),
        .i_col          (w_head_col),
        .i_attr         ({r_background, r_foreground}),
        .o_pop          (w_pop),
        .o_cursor       (w_cursor),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_address (o_cell_address),
        .o_cell_value   (o_cell_value)
    );

`ifndef SYNTH
    // Cursor never leaves the screen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cursor <= POS_W'(LAST_CELL))
        else $error("cursor beyond last cell");

    // Back end only consumes commands that are queued
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("pop from empty queue");

    // Reset leaves the queue empty, no output beat pending and the cursor at cell 0
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && !w_head_valid && w_cursor == '0))
        else $error("state not cleared by reset");
`endif

endmodule

/* dv/text_console_cell_writer_tb.sv */
// Testbench for text_console_cell_writer: drives characters and cursor gotos, predicts each
// cell write, and compares every output beat against the prediction.
// Depends on tccw_pkg and the text_console_cell_writer RTL.
`timescale 1ns / 100ps

module text_console_cell_writer_tb;
    import tccw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int LAST_POS    = COLUMNS * ROWS - 1;
    localparam int CLK_PERIOD  = 12;
    localparam int RESET_LEN   = 10;
    localparam int SETTLE      = 4;     // slack through the queue and output register; leave margin
    localparam int STALL_LIMIT = 3000;  // cycles with no beat on either channel

    typedef struct packed {
        logic                kind;
        logic [CHAR_W-1:0]   char_code;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
    } console_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        address;
        logic [ATTR_W+CHAR_W-1:0] value;
    } cell_write_t;

    // Predicts cell writes from accepted items and checks output beats in order
    class cell_write_scoreboard;
        cell_write_t       pending_writes[$];
        int unsigned       cursor;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        int                errors;
        int                n_items;
        int                n_writes;
        int                n_gotos;
        int                n_backspaces;
        int                n_newlines;

        function new();
            cursor = 0;
            fg = '0;
            bg = '0;
            errors = 0;
            n_items = 0;
            n_writes = 0;
            n_gotos = 0;
            n_backspaces = 0;
            n_newlines = 0;
        endfunction

        function int unsigned clamp_to_screen(int unsigned pos);
            return (pos > LAST_POS) ? LAST_POS : pos;
        endfunction

        function void write_reg(logic index, logic [COLOR_W-1:0] data);
            if (index == REG_FOREGROUND)
                fg = data;
            else
                bg = data;
        endfunction

        function void push_write(logic [CHAR_W-1:0] code);
            cell_write_t w;
            w.address = ADDR_W'(cursor);
            w.value   = {bg, fg, code};
            pending_writes.push_back(w);
        endfunction

        // Cursor update and expected write for one accepted input beat
        function void note_item(console_item_t it);
            n_items++;
            if (it.kind == KIND_GOTO) begin
                n_gotos++;
                cursor = clamp_to_screen(int'(it.row) * COLUMNS + int'(it.column));
            end else if (it.char_code == CH_BACKSPACE) begin
                n_backspaces++;
                if (cursor > 0)
                    cursor--;
                push_write(CH_SPACE);
            end else if (it.char_code == CH_LINEFEED || it.char_code == CH_RETURN) begin
                n_newlines++;
                cursor = clamp_to_screen(cursor + COLUMNS - (cursor % COLUMNS));
            end else begin
                push_write(it.char_code);
                cursor = clamp_to_screen(cursor + 1);
            end
        endfunction

        function void check_write(logic [ADDR_W-1:0] address, logic [ATTR_W+CHAR_W-1:0] value);
            cell_write_t w;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected cell write, address %0d value %h", $time, address,
                         value);
                errors++;
                return;
            end
            w = pending_writes.pop_front();
            n_writes++;
            if (address !== w.address) begin
                $display("%0t: cell_address expected %0d actual %0d", $time, w.address,
                         address);
                errors++;
            end
            if (value !== w.value) begin
                $display("%0t: cell_value expected %h actual %h", $time, w.value, value);
                errors++;
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_index;
    logic [COLOR_W-1:0]         i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_kind;
    logic [CHAR_W-1:0]          i_char_code;
    logic [COLUMN_W-1:0]        i_target_column;
    logic [ROW_W-1:0]           i_target_row;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [ADDR_W-1:0]          o_cell_address;
    logic [ATTR_W+CHAR_W-1:0]   o_cell_value;

    cell_write_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    text_console_cell_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_target_column(i_target_column),
        .i_target_row   (i_target_row),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_address (o_cell_address),
        .o_cell_value   (o_cell_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: check output beats first, then predict from the input beat of this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_write(o_cell_address, o_cell_value);
            if (i_in_valid && o_in_ready)
                sb.note_item('{i_kind, i_char_code, i_target_column, i_target_row});
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);

            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d writes outstanding", $time,
                         STALL_LIMIT, sb.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic console_item_t make_item(logic kind, int code, int column, int row);
        console_item_t it;
        it.kind      = kind;
        it.char_code = CHAR_W'(code);
        it.column    = COLUMN_W'(column);
        it.row       = ROW_W'(row);
        return it;
    endfunction

    // Mostly characters with a fair share of control codes and gotos; gotos lean toward
    // the bottom row so the cursor often sits at the last cell
    function automatic console_item_t random_item();
        console_item_t it;
        int unsigned   pick;
        it.kind      = KIND_CHAR;
        it.char_code = CHAR_W'($urandom_range(0, 255));
        it.column    = COLUMN_W'($urandom_range(0, 127));
        it.row       = ROW_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            it.kind = KIND_GOTO;
        end else if (pick < 13) begin
            it.kind   = KIND_GOTO;
            it.column = COLUMN_W'($urandom_range(0, COLUMNS - 1));
            it.row    = ROW_W'($urandom_range(0, ROWS - 1));
        end else if (pick < 17) begin
            it.kind   = KIND_GOTO;
            it.column = COLUMN_W'($urandom_range(COLUMNS - 8, COLUMNS - 1));
            it.row    = ROW_W'(ROWS - 1);
        end else if (pick < 27) begin
            it.char_code = CH_BACKSPACE;
        end else if (pick < 33) begin
            it.char_code = CH_LINEFEED;
        end else if (pick < 37) begin
            it.char_code = CH_RETURN;
        end
        return it;
    endfunction

    // One input beat, with random idle cycles ahead of it
    task automatic send_item(console_item_t it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= it.kind;
        i_char_code     <= it.char_code;
        i_target_column <= it.column;
        i_target_row    <= it.row;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending and wait for every predicted write plus pipeline slack
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, int data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= COLOR_W'(data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_colors(int fg, int bg);
        write_reg(REG_FOREGROUND, fg);
        write_reg(REG_BACKGROUND, bg);
    endtask

    task automatic run_random(int count, int send_pct, int recv_pct, int pause_at);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                drain();
            send_item(random_item());
        end
        drain();
    endtask

    console_item_t directed[$];

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_FOREGROUND;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_kind          <= KIND_CHAR;
        i_char_code     <= '0;
        i_target_column <= '0;
        i_target_row    <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset colors: goto ignores char, backspace at first cell,
        // byte extremes, newlines, off-screen gotos, overwrite and newline at the last cell
        directed.push_back(make_item(KIND_GOTO, CH_BACKSPACE, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_BACKSPACE, 0, 0));
        directed.push_back(make_item(KIND_CHAR, 8'h00, 0, 0));
        directed.push_back(make_item(KIND_CHAR, 8'hFF, 127, 31));
        directed.push_back(make_item(KIND_CHAR, 8'h41, 5, 3));
        directed.push_back(make_item(KIND_CHAR, CH_RETURN, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_LINEFEED, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_BACKSPACE, 0, 0));
        directed.push_back(make_item(KIND_GOTO, 8'h41, 127, 0));
        directed.push_back(make_item(KIND_CHAR, 8'h7F, 0, 0));
        directed.push_back(make_item(KIND_GOTO, 8'h00, COLUMNS - 1, ROWS - 1));
        directed.push_back(make_item(KIND_CHAR, 8'h5A, 0, 0));
        directed.push_back(make_item(KIND_CHAR, 8'h59, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_LINEFEED, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_RETURN, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_SPACE, 0, 0));
        directed.push_back(make_item(KIND_GOTO, 8'hFF, 127, 31));
        directed.push_back(make_item(KIND_CHAR, CH_BACKSPACE, 0, 0));
        directed.push_back(make_item(KIND_GOTO, CH_LINEFEED, 0, ROWS - 1));
        directed.push_back(make_item(KIND_CHAR, 8'h55, 0, 0));
        directed.push_back(make_item(KIND_CHAR, CH_LINEFEED, 0, 0));
        directed.push_back(make_item(KIND_GOTO, 8'hAA, 42, 21));
        directed.push_back(make_item(KIND_CHAR, 8'hAA, 0, 0));
        directed.push_back(make_item(KIND_GOTO, 8'h55, 85, 10));
        directed.push_back(make_item(KIND_CHAR, 8'h80, 0, 0));
        send_idle_pct = 10;
        recv_idle_pct = 10;
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        // Random phases: receiver-heavy idling, sender-heavy idling, then full rate
        set_colors(15, 0);
        run_random(217, 23, 60, 100);
        set_colors(0, 15);
        run_random(217, 60, 23, -1);
        set_colors($urandom_range(0, 15), $urandom_range(0, 15));
        run_random(216, 0, 0, -1);

        repeat (2 * SETTLE) @(posedge i_clk);
        $display("covered %0d items: %0d gotos, %0d backspaces, %0d newlines",
                 sb.n_items, sb.n_gotos, sb.n_backspaces, sb.n_newlines);
        $display("%0d cell writes checked over four color settings, %0d mismatches",
                 sb.n_writes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/tccw_pkg.sv
src/tccw_front.sv
src/tccw_fifo.sv
src/tccw_back.sv
src/text_console_cell_writer.sv
dv/text_console_cell_writer_tb.sv
